>>> hdl/pcm_pkg.sv
// shared widths, types and constants for the pair collision pipeline
package pcm_pkg;

  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;

  localparam int unsigned SQ_IN_W = 48;
  localparam int unsigned ROOT_W  = 24;
  localparam int unsigned NUM_W   = 48;
  localparam int unsigned DEN_W   = 24;
  localparam int unsigned QUO_W   = NUM_W - DEN_W;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_RIGHT,
    DIR_TOP,
    DIR_BOTTOM
  } edge_dir_e;

  typedef struct packed {
    logic               rr;
    logic               cc;
    logic               flip;
    logic               en;
    logic signed [23:0] c_x;
    logic signed [23:0] c_y;
    logic [22:0]        c_r;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;
    logic signed [24:0] r_r;
    logic signed [24:0] r_b;
    logic signed [24:0] cdx;
    logic signed [24:0] cdy;
    logic [23:0]        rs;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] bx;
    logic signed [23:0] by;
    logic signed [24:0] ar;
    logic signed [24:0] ab;
    logic signed [24:0] br;
    logic signed [24:0] bb;
  } st1_t;

  typedef struct packed {
    logic               rr;
    logic               cc;
    logic               flip;
    logic               en;
    logic [22:0]        c_r;
    logic               neg_x;
    logic               neg_y;
    logic [25:0]        mdx;
    logic [25:0]        mdy;
    logic [23:0]        rad;
    logic signed [25:0] l;
    logic signed [25:0] rt;
    logic signed [25:0] t;
    logic signed [25:0] bt;
    logic signed [25:0] ox;
    logic signed [25:0] oy;
    logic               rr_negx;
    logic               rr_negy;
  } st2_t;

  typedef struct packed {
    logic               rr;
    logic               cc;
    logic               flip;
    logic               en;
    logic [22:0]        c_r;
    logic               neg_x;
    logic               neg_y;
    logic [51:0]        sqx;
    logic [51:0]        sqy;
    logic [47:0]        rad2;
    logic signed [25:0] m1;
    logic signed [25:0] m2;
    logic               m1_rt;
    logic               m2_bt;
    logic               rr_hit;
    logic signed [25:0] rr_px;
    logic signed [25:0] rr_py;
    logic [23:0]        mx;
    logic [23:0]        my;
    logic [23:0]        rad;
  } st3_t;

  typedef struct packed {
    logic               hit;
    logic               mover_b;
    logic               use_div;
    logic               neg_x;
    logic               neg_y;
    logic signed [25:0] fx;
    logic signed [25:0] fy;
  } side_t;

  typedef struct packed {
    logic [23:0] rad;
    logic [23:0] mx;
    logic [23:0] my;
  } geo_t;

  typedef struct packed {
    logic               hit;
    logic               mover_b;
    logic signed [25:0] px;
    logic signed [25:0] py;
  } out_t;

endpackage

>>> hdl/pcm_isqrt.sv
// pipelined integer square root, one result bit per stage
module pcm_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [pcm_pkg::SQ_IN_W-1:0]  sq_i,
  output logic [pcm_pkg::ROOT_W-1:0]   root_o
);
  import pcm_pkg::*;

  localparam int unsigned STEPS = ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W-1:0]   rem_q  [STEPS];
  logic [ROOT_W-1:0]  root_q [STEPS];
  logic [SQ_IN_W-1:0] val_q  [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic [SQ_IN_W-1:0] val_in;
    logic [REM_W+1:0]   cand;
    logic [REM_W+1:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = sq_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign val_in  = val_q[j-1];
    end

    assign cand  = {rem_in, val_in[SQ_IN_W-1-2*j -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[j] <= val_in;
        if (cand >= trial) begin
          rem_q[j]  <= REM_W'(cand - trial);
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= REM_W'(cand);
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[STEPS-1];

endmodule

>>> hdl/pcm_div.sv
// pipelined restoring divider, one quotient bit per stage
module pcm_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [pcm_pkg::NUM_W-1:0]  num_i,
  input  logic [pcm_pkg::DEN_W-1:0]  den_i,
  output logic [pcm_pkg::QUO_W-1:0]  quo_o
);
  import pcm_pkg::*;

  logic [DEN_W-1:0] r_q [QUO_W];
  logic [QUO_W-1:0] q_q [QUO_W];
  logic [QUO_W-1:0] n_q [QUO_W];
  logic [DEN_W-1:0] d_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DEN_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [QUO_W-1:0] n_in;
    logic [DEN_W-1:0] d_in;
    logic [DEN_W:0]   cand;

    if (j == 0) begin : g_first
      assign r_in = num_i[NUM_W-1 -: DEN_W];
      assign q_in = '0;
      assign n_in = num_i[QUO_W-1:0];
      assign d_in = den_i;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign q_in = q_q[j-1];
      assign n_in = n_q[j-1];
      assign d_in = d_q[j-1];
    end

    assign cand = {r_in, n_in[QUO_W-1-j]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j] <= n_in;
        d_q[j] <= d_in;
        if (cand >= {1'b0, d_in}) begin
          r_q[j] <= DEN_W'(cand - {1'b0, d_in});
          q_q[j] <= {q_in[QUO_W-2:0], 1'b1};
        end else begin
          r_q[j] <= cand[DEN_W-1:0];
          q_q[j] <= {q_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = q_q[QUO_W-1];

endmodule

>>> hdl/pair_collision_mtv.sv
// pair collision test with minimum translation vector, top level
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata: both objects, tuser: shape kinds
//  m_axis   out  m_axis_tvalid/tready   tdata: hit, mover, push x/y
//
//  one word per cycle in and out, unless the output buffer is full or m_axis_tready is low
//  each word passes the 24-stage square root and the 24-stage divider in series
//  a two-word output buffer holds results; the pipeline freezes only when it is full
//  reset clears valid bits and buffer pointers, payload registers are not reset
module pair_collision_mtv (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_x, a_y, a_width, a_height, a_enabled, b_x, b_y, b_width, b_height, b_enabled
  input  logic [pcm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // a_is_rect, b_is_rect
  input  logic [pcm_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit, mover_is_b, push_x, push_y
  output logic [pcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import pcm_pkg::*;

  localparam int unsigned ST_SQ = 4;
  localparam int unsigned ST_RT = ST_SQ + ROOT_W;
  localparam int unsigned ST_DV = ST_RT + 3;
  localparam int unsigned NST   = ST_DV + QUO_W;

  logic               en;
  logic               push;
  logic               pop;
  logic [NST:1]       vld_q;

  logic signed [23:0] ax, ay, bx, by;
  logic [22:0]        aw, ah, bw, bh;
  logic               a_rect, b_rect, a_en, b_en;
  logic [22:0]        r_w, r_h;

  st1_t               s1_d, s1_q;
  st2_t               s2_d, s2_q;
  st3_t               s3_d, s3_q;

  logic signed [24:0] qx, qy;
  logic signed [25:0] crdx, crdy, dx, dy;
  logic signed [24:0] mn_x, mx_x, mn_y, mx_y;

  logic [51:0]        s_sum;
  logic [SQ_IN_W-1:0] s_q;
  logic               hit_c, zero_s;
  logic signed [25:0] m_in, mag_in, ix, iy;
  edge_dir_e          dir;
  side_t              side_d;
  side_t              side_q [ST_SQ:NST];
  geo_t               geo_d;
  geo_t               geo_q  [ST_SQ:ST_RT];

  logic [ROOT_W-1:0]  root;
  logic [23:0]        dep_q, mx29_q, my29_q, dist29_q;
  logic [47:0]        prx_q, pry_q;
  logic [23:0]        dist30_q;
  logic [NUM_W-1:0]   nx_q, ny_q;
  logic [DEN_W-1:0]   den_q;
  logic [QUO_W-1:0]   qxo, qyo;

  out_t               res;
  out_t               fifo_q [2];
  out_t               head;
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;

  // unpack
  assign ax     = $signed(s_axis_tdata[23:0]);
  assign ay     = $signed(s_axis_tdata[47:24]);
  assign aw     = s_axis_tdata[70:48];
  assign ah     = s_axis_tdata[93:71];
  assign a_en   = s_axis_tdata[94];
  assign bx     = $signed(s_axis_tdata[118:95]);
  assign by     = $signed(s_axis_tdata[142:119]);
  assign bw     = s_axis_tdata[165:143];
  assign bh     = s_axis_tdata[188:166];
  assign b_en   = s_axis_tdata[189];
  assign a_rect = s_axis_tuser[0];
  assign b_rect = s_axis_tuser[1];

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-1:1], s_axis_tvalid};
    end
  end

  // stage 1: shape selection and edges
  always_comb begin
    s1_d      = '0;
    s1_d.rr   = a_rect & b_rect;
    s1_d.cc   = ~a_rect & ~b_rect;
    s1_d.flip = a_rect & ~b_rect;
    s1_d.en   = a_en & b_en;
    s1_d.c_x  = s1_d.flip ? bx : ax;
    s1_d.c_y  = s1_d.flip ? by : ay;
    s1_d.c_r  = s1_d.flip ? bw : aw;
    s1_d.r_x  = s1_d.flip ? ax : bx;
    s1_d.r_y  = s1_d.flip ? ay : by;
    r_w       = s1_d.flip ? aw : bw;
    r_h       = s1_d.flip ? ah : bh;
    s1_d.r_r  = 25'(s1_d.r_x) + $signed({2'b00, r_w});
    s1_d.r_b  = 25'(s1_d.r_y) + $signed({2'b00, r_h});
    s1_d.cdx  = 25'(bx) - 25'(ax);
    s1_d.cdy  = 25'(by) - 25'(ay);
    s1_d.rs   = {1'b0, aw} + {1'b0, bw};
    s1_d.ax   = ax;
    s1_d.ay   = ay;
    s1_d.bx   = bx;
    s1_d.by   = by;
    s1_d.ar   = 25'(ax) + $signed({2'b00, aw});
    s1_d.ab   = 25'(ay) + $signed({2'b00, ah});
    s1_d.br   = 25'(bx) + $signed({2'b00, bw});
    s1_d.bb   = 25'(by) + $signed({2'b00, bh});
  end

  // stage 2: closest point, displacement, overlaps
  always_comb begin
    qx = ($signed(s1_q.c_x) < $signed(s1_q.r_x)) ? 25'($signed(s1_q.r_x)) :
         ((25'($signed(s1_q.c_x)) > $signed(s1_q.r_r)) ? $signed(s1_q.r_r) :
          25'($signed(s1_q.c_x)));
    qy = ($signed(s1_q.c_y) < $signed(s1_q.r_y)) ? 25'($signed(s1_q.r_y)) :
         ((25'($signed(s1_q.c_y)) > $signed(s1_q.r_b)) ? $signed(s1_q.r_b) :
          25'($signed(s1_q.c_y)));
    crdx = 26'($signed(s1_q.c_x)) - 26'(qx);
    crdy = 26'($signed(s1_q.c_y)) - 26'(qy);
    dx   = s1_q.cc ? 26'($signed(s1_q.cdx)) : crdx;
    dy   = s1_q.cc ? 26'($signed(s1_q.cdy)) : crdy;
    mn_x = ($signed(s1_q.ar) < $signed(s1_q.br)) ? $signed(s1_q.ar) : $signed(s1_q.br);
    mn_y = ($signed(s1_q.ab) < $signed(s1_q.bb)) ? $signed(s1_q.ab) : $signed(s1_q.bb);
    mx_x = ($signed(s1_q.ax) > $signed(s1_q.bx)) ? 25'($signed(s1_q.ax)) :
           25'($signed(s1_q.bx));
    mx_y = ($signed(s1_q.ay) > $signed(s1_q.by)) ? 25'($signed(s1_q.ay)) :
           25'($signed(s1_q.by));

    s2_d         = '0;
    s2_d.rr      = s1_q.rr;
    s2_d.cc      = s1_q.cc;
    s2_d.flip    = s1_q.flip;
    s2_d.en      = s1_q.en;
    s2_d.c_r     = s1_q.c_r;
    s2_d.neg_x   = dx[25];
    s2_d.neg_y   = dy[25];
    s2_d.mdx     = dx[25] ? 26'(-dx) : 26'(dx);
    s2_d.mdy     = dy[25] ? 26'(-dy) : 26'(dy);
    s2_d.rad     = s1_q.cc ? s1_q.rs : {1'b0, s1_q.c_r};
    s2_d.l       = 26'($signed(s1_q.c_x)) - 26'($signed(s1_q.r_x));
    s2_d.rt      = 26'($signed(s1_q.r_r)) - 26'($signed(s1_q.c_x));
    s2_d.t       = 26'($signed(s1_q.c_y)) - 26'($signed(s1_q.r_y));
    s2_d.bt      = 26'($signed(s1_q.r_b)) - 26'($signed(s1_q.c_y));
    s2_d.ox      = 26'(mn_x) - 26'(mx_x);
    s2_d.oy      = 26'(mn_y) - 26'(mx_y);
    s2_d.rr_negx = (26'($signed(s1_q.ax)) + 26'($signed(s1_q.ar))) <
                   (26'($signed(s1_q.bx)) + 26'($signed(s1_q.br)));
    s2_d.rr_negy = (26'($signed(s1_q.ay)) + 26'($signed(s1_q.ab))) <
                   (26'($signed(s1_q.by)) + 26'($signed(s1_q.bb)));
  end

  // stage 3: squares, nearest edge pairs, box push
  always_comb begin
    s3_d        = '0;
    s3_d.rr     = s2_q.rr;
    s3_d.cc     = s2_q.cc;
    s3_d.flip   = s2_q.flip;
    s3_d.en     = s2_q.en;
    s3_d.c_r    = s2_q.c_r;
    s3_d.neg_x  = s2_q.neg_x;
    s3_d.neg_y  = s2_q.neg_y;
    s3_d.sqx    = 52'(s2_q.mdx) * 52'(s2_q.mdx);
    s3_d.sqy    = 52'(s2_q.mdy) * 52'(s2_q.mdy);
    s3_d.rad2   = 48'(s2_q.rad) * 48'(s2_q.rad);
    s3_d.m1_rt  = $signed(s2_q.rt) < $signed(s2_q.l);
    s3_d.m1     = s3_d.m1_rt ? s2_q.rt : s2_q.l;
    s3_d.m2_bt  = $signed(s2_q.bt) < $signed(s2_q.t);
    s3_d.m2     = s3_d.m2_bt ? s2_q.bt : s2_q.t;
    s3_d.rr_hit = ($signed(s2_q.ox) > 26'sd0) && ($signed(s2_q.oy) > 26'sd0);
    if ($signed(s2_q.ox) < $signed(s2_q.oy)) begin
      s3_d.rr_px = s2_q.rr_negx ? -$signed(s2_q.ox) : $signed(s2_q.ox);
      s3_d.rr_py = '0;
    end else begin
      s3_d.rr_px = '0;
      s3_d.rr_py = s2_q.rr_negy ? -$signed(s2_q.oy) : $signed(s2_q.oy);
    end
    s3_d.mx     = s2_q.mdx[23:0];
    s3_d.my     = s2_q.mdy[23:0];
    s3_d.rad    = s2_q.rad;
  end

  // stage 4: distance test and the cases that need no division
  always_comb begin
    s_sum  = s3_q.sqx + s3_q.sqy;
    hit_c  = (s_sum <= {4'b0000, s3_q.rad2});
    zero_s = (s_sum == '0);
    if ($signed(s3_q.m1) <= $signed(s3_q.m2)) begin
      m_in = s3_q.m1;
      dir  = s3_q.m1_rt ? DIR_RIGHT : DIR_LEFT;
    end else begin
      m_in = s3_q.m2;
      dir  = s3_q.m2_bt ? DIR_BOTTOM : DIR_TOP;
    end
    mag_in = $signed({3'b000, s3_q.c_r}) + m_in;
    case (dir)
      DIR_LEFT: begin
        ix = -mag_in;
        iy = '0;
      end
      DIR_RIGHT: begin
        ix = mag_in;
        iy = '0;
      end
      DIR_TOP: begin
        ix = '0;
        iy = -mag_in;
      end
      DIR_BOTTOM: begin
        ix = '0;
        iy = mag_in;
      end
      default: begin
        ix = '0;
        iy = '0;
      end
    endcase
    if (s3_q.flip) begin
      ix = -ix;
      iy = -iy;
    end

    side_d         = '0;
    side_d.hit     = s3_q.en & (s3_q.rr ? s3_q.rr_hit : hit_c);
    side_d.mover_b = side_d.hit & s3_q.cc;
    side_d.use_div = side_d.hit & ~s3_q.rr & ~zero_s;
    side_d.neg_x   = s3_q.neg_x ^ s3_q.flip;
    side_d.neg_y   = s3_q.neg_y ^ s3_q.flip;
    if (side_d.hit && s3_q.rr) begin
      side_d.fx = s3_q.rr_px;
      side_d.fy = s3_q.rr_py;
    end else if (side_d.hit && zero_s && !s3_q.cc) begin
      side_d.fx = ix;
      side_d.fy = iy;
    end

    geo_d.rad = s3_q.rad;
    geo_d.mx  = s3_q.mx;
    geo_d.my  = s3_q.my;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q          <= s1_d;
      s2_q          <= s2_d;
      s3_q          <= s3_d;
      s_q           <= s_sum[SQ_IN_W-1:0];
      side_q[ST_SQ] <= side_d;
      geo_q[ST_SQ]  <= geo_d;
      for (int k = ST_SQ + 1; k <= NST; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int k = ST_SQ + 1; k <= ST_RT; k++) begin
        geo_q[k] <= geo_q[k-1];
      end
    end
  end

  pcm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sq_i   (s_q),
    .root_o (root)
  );

  // depth, products and rounding offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      dep_q    <= geo_q[ST_RT].rad - root;
      mx29_q   <= geo_q[ST_RT].mx;
      my29_q   <= geo_q[ST_RT].my;
      dist29_q <= root;
      prx_q    <= 48'(mx29_q) * 48'(dep_q);
      pry_q    <= 48'(my29_q) * 48'(dep_q);
      dist30_q <= dist29_q;
      nx_q     <= prx_q + 48'(dist30_q >> 1);
      ny_q     <= pry_q + 48'(dist30_q >> 1);
      den_q    <= dist30_q;
    end
  end

  pcm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nx_q),
    .den_i (den_q),
    .quo_o (qxo)
  );

  pcm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (den_q),
    .quo_o (qyo)
  );

  always_comb begin
    res.hit     = side_q[NST].hit;
    res.mover_b = side_q[NST].mover_b;
    if (side_q[NST].use_div) begin
      res.px = side_q[NST].neg_x ? -$signed({2'b00, qxo}) : $signed({2'b00, qxo});
      res.py = side_q[NST].neg_y ? -$signed({2'b00, qyo}) : $signed({2'b00, qyo});
    end else begin
      res.px = side_q[NST].fx;
      res.py = side_q[NST].fy;
    end
  end

  // two-word output buffer
  assign push          = en & vld_q[NST];
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tdata  = {2'b00, head.py, head.px, head.mover_b, head.hit};

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> hdl/pcm_checker.sv
// port-level checks on the result stream, bound to the top level
module pcm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [pcm_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import pcm_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // no hit means no mover and no push
  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_DATA_W-1:1] == '0)
    else $error("push or mover without hit");

  // second object moves only on a hit
  a_mover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("mover set without hit");

  // nothing leaves during reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind pair_collision_mtv pcm_checker u_pcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_pair_collision_mtv.sv
// testbench for pair_collision_mtv: streamed shape pairs checked against a behavioral collision predictor
`timescale 1ns / 1ps
module tb_pair_collision_mtv;
  import pcm_pkg::*;

  typedef struct packed {
    logic [IN_USER_W-1:0] user;
    logic [IN_DATA_W-1:0] data;
  } pair_word_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  pair_word_t pending_pairs[$];
  logic [OUT_DATA_W-1:0] expected_mtv[$];
  int  idle_pct;
  int  stall_pct;
  int  mismatches;
  int  accepted;
  bit  pair_taken;

  pair_collision_mtv i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint floor_root(longint s);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint push_share(longint d, longint depth, longint span);
    longint q;
    q = (mag(d) * depth + span / 2) / span;
    return d < 0 ? -q : q;
  endfunction

  function automatic bit box_box(longint ax, longint ay, longint aw, longint ah,
                                 longint bx, longint by, longint bw, longint bh,
                                 output longint px, output longint py);
    longint ar, ab, br, bb, ox, oy;
    ar = ax + aw;
    ab = ay + ah;
    br = bx + bw;
    bb = by + bh;
    ox = (ar < br ? ar : br) - (ax > bx ? ax : bx);
    oy = (ab < bb ? ab : bb) - (ay > by ? ay : by);
    px = 0;
    py = 0;
    if (ox <= 0 || oy <= 0) return 0;
    if (ox < oy) px = (ax + ar < bx + br) ? -ox : ox;
    else py = (ay + ab < by + bb) ? -oy : oy;
    return 1;
  endfunction

  function automatic bit disc_box(longint cx, longint cy, longint r,
                                  longint rx, longint ry, longint w, longint h,
                                  output longint px, output longint py);
    longint qx, qy, dx, dy, s, l, rt, t, bt, m, span;
    qx = cx < rx ? rx : (cx > rx + w ? rx + w : cx);
    qy = cy < ry ? ry : (cy > ry + h ? ry + h : cy);
    dx = cx - qx;
    dy = cy - qy;
    s = dx * dx + dy * dy;
    px = 0;
    py = 0;
    if (s > r * r) return 0;
    if (s == 0) begin
      l = cx - rx;
      rt = rx + w - cx;
      t = cy - ry;
      bt = ry + h - cy;
      m = l;
      if (rt < m) m = rt;
      if (t < m) m = t;
      if (bt < m) m = bt;
      if (m == l) px = -(r + m);
      else if (m == rt) px = r + m;
      else if (m == t) py = -(r + m);
      else py = r + m;
      return 1;
    end
    span = floor_root(s);
    px = push_share(dx, r - span, span);
    py = push_share(dy, r - span, span);
    return 1;
  endfunction

  function automatic bit disc_disc(longint ax, longint ay, longint ar,
                                   longint bx, longint by, longint br,
                                   output longint px, output longint py);
    longint dx, dy, s, rs, span;
    dx = bx - ax;
    dy = by - ay;
    s = dx * dx + dy * dy;
    rs = ar + br;
    px = 0;
    py = 0;
    if (s > rs * rs) return 0;
    if (s != 0) begin
      span = floor_root(s);
      px = push_share(dx, rs - span, span);
      py = push_share(dy, rs - span, span);
    end
    return 1;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_mtv(pair_word_t w);
    longint ax, ay, aw, ah, bx, by, bw, bh, px, py;
    bit a_box, b_box, en, hit, mover_b;
    logic [OUT_DATA_W-1:0] res;
    a_box = w.user[0];
    b_box = w.user[1];
    ax = longint'($signed(w.data[23:0]));
    ay = longint'($signed(w.data[47:24]));
    aw = longint'(w.data[70:48]);
    ah = longint'(w.data[93:71]);
    bx = longint'($signed(w.data[118:95]));
    by = longint'($signed(w.data[142:119]));
    bw = longint'(w.data[165:143]);
    bh = longint'(w.data[188:166]);
    en = w.data[94] && w.data[189];
    hit = 0;
    mover_b = 0;
    px = 0;
    py = 0;
    if (en) begin
      if (a_box && b_box) begin
        hit = box_box(ax, ay, aw, ah, bx, by, bw, bh, px, py);
      end else if (!a_box && b_box) begin
        hit = disc_box(ax, ay, aw, bx, by, bw, bh, px, py);
      end else if (a_box && !b_box) begin
        hit = disc_box(bx, by, bw, ax, ay, aw, ah, px, py);
        px = -px;
        py = -py;
      end else begin
        hit = disc_disc(ax, ay, aw, bx, by, bw, px, py);
        mover_b = 1;
      end
    end
    if (!hit) begin
      px = 0;
      py = 0;
      mover_b = 0;
    end
    res = '0;
    res[0] = hit;
    res[1] = mover_b;
    res[27:2] = px[25:0];
    res[53:28] = py[25:0];
    return res;
  endfunction

  function automatic pair_word_t make_pair(bit ab, longint ax, longint ay, longint aw,
                                           longint ah, bit ae, bit bb, longint bx,
                                           longint by, longint bw, longint bh, bit be);
    pair_word_t w;
    w = '0;
    w.user = {bb, ab};
    w.data[23:0] = ax[23:0];
    w.data[47:24] = ay[23:0];
    w.data[70:48] = aw[22:0];
    w.data[93:71] = ah[22:0];
    w.data[94] = ae;
    w.data[118:95] = bx[23:0];
    w.data[142:119] = by[23:0];
    w.data[165:143] = bw[22:0];
    w.data[188:166] = bh[22:0];
    w.data[189] = be;
    return w;
  endfunction

  function automatic pair_word_t random_pair();
    pair_word_t w;
    longint ax, ay, aw, ah, bx, by, bw, bh;
    if ($urandom_range(0, 9) == 0) begin
      w = '0;
      w.data[95:0] = {$urandom, $urandom, $urandom};
      w.data[189:96] = 94'({$urandom, $urandom, $urandom});
      w.user = IN_USER_W'($urandom);
      return w;
    end
    ax = longint'($urandom_range(0, 8000)) - 4000;
    ay = longint'($urandom_range(0, 8000)) - 4000;
    aw = longint'($urandom_range(0, 3000));
    ah = longint'($urandom_range(0, 3000));
    bx = ax + longint'($urandom_range(0, 8000)) - 4000;
    by = ay + longint'($urandom_range(0, 8000)) - 4000;
    bw = longint'($urandom_range(0, 3000));
    bh = longint'($urandom_range(0, 3000));
    return make_pair(1'($urandom_range(0, 1)), ax, ay, aw, ah, $urandom_range(0, 15) != 0,
                     1'($urandom_range(0, 1)), bx, by, bw, bh, $urandom_range(0, 15) != 0);
  endfunction

  // stimulus driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || pair_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          {s_axis_tuser, s_axis_tdata} <= pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  // input and output monitor
  always @(posedge clk_i) begin
    logic [OUT_DATA_W-1:0] exp_word;
    pair_taken = s_axis_tvalid && s_axis_tready;
    if (pair_taken) begin
      expected_mtv.push_back(predict_mtv({s_axis_tuser, s_axis_tdata}));
      accepted++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_mtv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        exp_word = expected_mtv.pop_front();
        if (exp_word[0] !== m_axis_tdata[0] || exp_word[1] !== m_axis_tdata[1] ||
            exp_word[27:2] !== m_axis_tdata[27:2] ||
            exp_word[53:28] !== m_axis_tdata[53:28]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit %b mover %b px %0d py %0d, got hit %b mover %b px %0d py %0d",
                     exp_word[0], exp_word[1], $signed(exp_word[27:2]),
                     $signed(exp_word[53:28]), m_axis_tdata[0], m_axis_tdata[1],
                     $signed(m_axis_tdata[27:2]), $signed(m_axis_tdata[53:28]));
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set = '{0, 59, 0, 18};
    stall_set = '{0, 0, 59, 18};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    accepted = 0;
    pair_taken = 0;
    // disabled, box pairs along x, y and tie, touching edges
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 0, 1, 500, 500, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 1, 900, 100, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 1, 100, -900, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 1, 500, 500, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 1, 1000, 0, 1000, 1000, 1));
    // circle against box: centre outside at an edge and a corner, touching, centre inside with each edge nearest
    pending_pairs.push_back(make_pair(0, -300, 500, 400, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, -400, 500, 400, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, -300, -300, 500, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, 500, 500, 300, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, 900, 500, 300, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, 500, 100, 300, 0, 1, 1, 0, 0, 1000, 1000, 1));
    pending_pairs.push_back(make_pair(0, 500, 900, 300, 0, 1, 1, 0, 0, 1000, 1000, 1));
    // box first, circle second
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 0, 1200, 300, 400, 0, 1));
    pending_pairs.push_back(make_pair(1, 0, 0, 1000, 1000, 1, 0, 200, 500, 100, 0, 1));
    // circle pairs: overlap, same centre, touching, apart
    pending_pairs.push_back(make_pair(0, 0, 0, 500, 0, 1, 0, 300, 400, 500, 0, 1));
    pending_pairs.push_back(make_pair(0, 10, 10, 500, 0, 1, 0, 10, 10, 200, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 300, 0, 1, 0, 600, 800, 700, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 0, 300, 0, 1, 0, 600, 800, 699, 0, 1));
    // field extremes
    pending_pairs.push_back(make_pair(0, -8388608, -8388608, 8388607, 8388607, 1,
                                      0, 8388607, 8388607, 8388607, 8388607, 1));
    pending_pairs.push_back(make_pair(1, -8388608, -8388608, 8388607, 8388607, 1,
                                      1, 8388607, 8388607, 8388607, 8388607, 1));
    pending_pairs.push_back(make_pair(0, 8388607, -8388608, 8388607, 0, 1,
                                      1, -8388608, -8388608, 8388607, 8388607, 1));
    pending_pairs.push_back(make_pair(1, -8388608, 8388607, 0, 0, 1,
                                      0, -8388608, 8388607, 0, 0, 1));
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int k = 0; k < 432; k++) pending_pairs.push_back(random_pair());
      while (pending_pairs.size() > 0) @(posedge clk_i);
    end
    while (s_axis_tvalid && !pair_taken) @(posedge clk_i);
    stall_pct = 0;
    while (expected_mtv.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && expected_mtv.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pcm_pkg.sv
hdl/pcm_isqrt.sv
hdl/pcm_div.sv
hdl/pair_collision_mtv.sv
hdl/pcm_checker.sv
dv/tb_pair_collision_mtv.sv
